FILE: hw/rtl/stcfp_pkg.sv
// Shared constants, types and helpers of the serial text command and frame parser.
package stcfp_pkg;

  localparam int PATTERN_LEN   = 11;
  localparam int CMD_LEN       = 11;
  localparam int HEADER_LEN    = 8;
  localparam int FRAME_TRAILER = 2;
  localparam int LEN_LO_IDX    = 6;
  localparam int LEN_HI_IDX    = 7;
  localparam int FILL_W        = $clog2(PATTERN_LEN + 1);
  localparam int HDR_IDX_W     = $clog2(HEADER_LEN);
  localparam int COUNT_W       = 17;

  localparam logic [7:0]           PREAMBLE_RESET = 8'hAA;
  localparam logic [COUNT_W-1:0]   COUNT_MAX      = '1;
  localparam logic [8*CMD_LEN-1:0] ALIVE_CMD      = "AREYOULIVE?";
  localparam logic [8*CMD_LEN-1:0] STATUS_CMD     = "ISSENSOROK?";

  typedef enum logic [1:0] {
    ACT_ALIVE       = 2'd0,
    ACT_STATUS_REQ  = 2'd1,
    ACT_SENSOR_OK   = 2'd2,
    ACT_FORWARD_CAN = 2'd3
  } action_t;

  typedef struct packed {
    logic alive;
    logic status;
  } text_hit_t;

  typedef struct packed {
    logic                      done;
    logic [8*HEADER_LEN-1:0]   header;
  } frame_end_t;

  // Character idx of a command, first character first; zero past its end.
  function automatic logic [7:0] cmd_char(input logic [8*CMD_LEN-1:0] cmd, input int idx);
    logic [7:0] ch;
    ch = 8'h00;
    if (idx < CMD_LEN) begin
      ch = cmd[8*(CMD_LEN-1-idx) +: 8];
    end
    return ch;
  endfunction

endpackage

FILE: hw/rtl/serial_text_command_and_frame_parser_unit.sv
// Top level: input register, mode control and result register of the parser.
//
//   channel   | handshake                 | payload
//   ----------+---------------------------+---------------------
//   input     | in_valid / in_ready       | rx_byte
//   result    | out_valid / out_ready     | action, can_payload
//   config    | cfg_we (no wait)          | cfg_wdata (preamble)
//
// One byte per cycle sustained while results are taken; a byte transfers into the input
// register, and its result is then registered from there into the result register.
// Reset clears the mode, wait flag, counters and both valid flags, and loads
// the preamble register with its default.
// While the result register holds an untaken result, the input register
// advances only in the cycle the result transfers; in_ready falls once it is full.
module serial_text_command_and_frame_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  action,
  output logic [63:0] can_payload,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);
  import stcfp_pkg::*;

  logic [7:0]              preamble;
  logic                    s1_valid;
  logic [7:0]              s1_byte;
  logic                    framing_active;
  logic                    awaiting;
  logic                    advance;
  logic                    is_pre;
  logic                    text_step;
  logic                    frame_start;
  logic                    frame_step;
  text_hit_t               hit;
  frame_end_t              fin;
  logic                    res_valid;
  action_t                 res_action;
  logic [8*HEADER_LEN-1:0] res_payload;
  logic                    framing_next;
  logic                    awaiting_next;
  action_t                 out_action;

  assign advance     = s1_valid && (!out_valid || out_ready);
  assign in_ready    = !s1_valid || advance;
  assign is_pre      = (s1_byte == preamble);
  assign text_step   = advance && !framing_active && !is_pre;
  assign frame_start = advance && !framing_active && is_pre;
  assign frame_step  = advance && framing_active;

  stcfp_text u_text (
    .clk     (clk),
    .rst     (rst),
    .step    (text_step),
    .clear   (frame_start),
    .rx_byte (s1_byte),
    .hit     (hit)
  );

  stcfp_frame u_frame (
    .clk     (clk),
    .rst     (rst),
    .start   (frame_start),
    .step    (frame_step),
    .rx_byte (s1_byte),
    .fin     (fin)
  );

  always_comb begin
    res_valid     = 1'b0;
    res_action    = ACT_ALIVE;
    res_payload   = '0;
    framing_next  = framing_active;
    awaiting_next = awaiting;
    if (frame_start) begin
      framing_next = 1'b1;
    end
    if (hit.alive) begin
      res_valid  = 1'b1;
      res_action = ACT_ALIVE;
    end else if (hit.status) begin
      res_valid     = 1'b1;
      res_action    = ACT_STATUS_REQ;
      awaiting_next = 1'b1;
    end else if (fin.done) begin
      res_valid    = 1'b1;
      framing_next = 1'b0;
      if (awaiting) begin
        res_action    = ACT_SENSOR_OK;
        awaiting_next = 1'b0;
      end else begin
        res_action  = ACT_FORWARD_CAN;
        res_payload = fin.header;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      preamble       <= PREAMBLE_RESET;
      s1_valid       <= 1'b0;
      framing_active <= 1'b0;
      awaiting       <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        preamble <= cfg_wdata;
      end
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      framing_active <= framing_next;
      awaiting       <= awaiting_next;
      // drop the result on transfer unless a new one replaces it
      if (advance) begin
        out_valid <= res_valid;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= rx_byte;
    end
    if (advance && res_valid) begin
      out_action  <= res_action;
      can_payload <= res_payload;
    end
  end

  assign action = out_action;

endmodule

FILE: hw/rtl/stcfp_text.sv
// Sliding text window with fill count and fixed command matchers.
module stcfp_text (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic                  clear,
  input  logic [7:0]            rx_byte,
  output stcfp_pkg::text_hit_t  hit
);
  import stcfp_pkg::*;

  logic [7:0]        window      [PATTERN_LEN];
  logic [7:0]        window_next [PATTERN_LEN];
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_inc;
  logic [FILL_W-1:0] fill_next;
  logic              full;
  logic              alive_eq;
  logic              status_eq;

  always_comb begin
    for (int i = 0; i < PATTERN_LEN - 1; i++) begin
      window_next[i] = window[i+1];
    end
    window_next[PATTERN_LEN-1] = rx_byte;

    fill_inc = (fill < FILL_W'(PATTERN_LEN)) ? fill + 1'b1 : fill;
    full     = (fill_inc >= FILL_W'(PATTERN_LEN));

    alive_eq  = 1'b1;
    status_eq = 1'b1;
    for (int i = 0; i < PATTERN_LEN; i++) begin
      if (window_next[i] != cmd_char(ALIVE_CMD, i)) begin
        alive_eq = 1'b0;
      end
      if (window_next[i] != cmd_char(STATUS_CMD, i)) begin
        status_eq = 1'b0;
      end
    end

    // alive command has priority over the status command
    hit.alive  = step && full && alive_eq;
    hit.status = step && full && !alive_eq && status_eq;

    fill_next = fill;
    if (clear) begin
      fill_next = '0;
    end else if (step) begin
      fill_next = (hit.alive || hit.status) ? '0 : fill_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill_next;
    end
  end

  // window contents only count once fill reaches the pattern length
  always_ff @(posedge clk) begin
    if (step) begin
      window <= window_next;
    end
  end

endmodule

FILE: hw/rtl/stcfp_frame.sv
// Frame byte counter, header store and frame end detection.
module stcfp_frame (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic                   step,
  input  logic [7:0]             rx_byte,
  output stcfp_pkg::frame_end_t  fin
);
  import stcfp_pkg::*;

  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_inc;
  logic [COUNT_W-1:0] count_next;
  logic [COUNT_W-1:0] end_at;
  logic [15:0]        dlen;
  logic [7:0]         header      [HEADER_LEN];
  logic [7:0]         header_next [HEADER_LEN];

  always_comb begin
    header_next = header;
    if (start) begin
      header_next[0] = rx_byte;
    end else if (step && (count < COUNT_W'(HEADER_LEN))) begin
      header_next[count[HDR_IDX_W-1:0]] = rx_byte;
    end

    count_inc = (count != COUNT_MAX) ? count + 1'b1 : count;
    dlen      = {header_next[LEN_HI_IDX], header_next[LEN_LO_IDX]};
    // end point is always past the header, so the length bytes are final here
    end_at    = COUNT_W'(HEADER_LEN + FRAME_TRAILER) + COUNT_W'(dlen);
    fin.done  = step && (count_inc >= end_at);

    for (int i = 0; i < HEADER_LEN; i++) begin
      fin.header[8*i +: 8] = header_next[i];
    end

    count_next = count;
    if (start) begin
      count_next = COUNT_W'(1);
    end else if (step) begin
      count_next = fin.done ? '0 : count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    header <= header_next;
  end

endmodule

FILE: hw/rtl/stcfp_checker.sv
// Port-level assertions for the parser top level, and the bind that attaches them.
module stcfp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  action,
  input logic [63:0] can_payload
);
  import stcfp_pkg::*;

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(action) && $stable(can_payload))
    else $error("result changed while stalled");

  // only a CAN forward carries header bytes
  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (action != ACT_FORWARD_CAN) |-> (can_payload == 64'd0))
    else $error("nonzero payload on a reply action");

  // a fresh result traces back to a byte transfer through the input and result registers
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a matching byte transfer");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind serial_text_command_and_frame_parser_unit stcfp_checker u_stcfp_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .action      (action),
  .can_payload (can_payload)
);
